// File: rtl/vmblk_pkg.sv
// shared types and constants of the virtio-mmio block register file
`default_nettype none
package vmblk_pkg;

   localparam int unsigned OP_WIDTH       = 2;
   localparam int unsigned OFFSET_WIDTH   = 12;
   localparam int unsigned WORD_WIDTH     = 32;
   localparam int unsigned ADDRESS_WIDTH  = 64;
   localparam int unsigned CAPACITY_WIDTH = 48;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_READ     = 2'd0,
      OP_WRITE    = 2'd1,
      OP_COMPLETE = 2'd2,
      OP_UNUSED   = 2'd3
   } operation_type;

   localparam logic [WORD_WIDTH-1:0] MAX_QUEUE_SIZE   = 32'd64;
   localparam logic [WORD_WIDTH-1:0] IDENTITY_MAGIC   = 32'h7472_6976;
   localparam logic [WORD_WIDTH-1:0] VERSION_VALUE    = 32'd2;
   localparam logic [WORD_WIDTH-1:0] DEVICE_ID_VALUE  = 32'd2;
   localparam logic [WORD_WIDTH-1:0] VENDOR_VALUE     = 32'h494D_5246;
   localparam int unsigned           DRIVER_OK_BIT    = 2;

   localparam logic [OFFSET_WIDTH-1:0] REG_MAGIC          = 12'h000;
   localparam logic [OFFSET_WIDTH-1:0] REG_VERSION        = 12'h004;
   localparam logic [OFFSET_WIDTH-1:0] REG_DEVICE_ID      = 12'h008;
   localparam logic [OFFSET_WIDTH-1:0] REG_VENDOR_ID      = 12'h00C;
   localparam logic [OFFSET_WIDTH-1:0] REG_DEV_FEATURES   = 12'h010;
   localparam logic [OFFSET_WIDTH-1:0] REG_DEV_FEAT_SEL   = 12'h014;
   localparam logic [OFFSET_WIDTH-1:0] REG_QUEUE_SEL      = 12'h030;
   localparam logic [OFFSET_WIDTH-1:0] REG_QUEUE_NUM_MAX  = 12'h034;
   localparam logic [OFFSET_WIDTH-1:0] REG_QUEUE_NUM      = 12'h038;
   localparam logic [OFFSET_WIDTH-1:0] REG_QUEUE_READY    = 12'h044;
   localparam logic [OFFSET_WIDTH-1:0] REG_QUEUE_NOTIFY   = 12'h050;
   localparam logic [OFFSET_WIDTH-1:0] REG_INT_STATUS     = 12'h060;
   localparam logic [OFFSET_WIDTH-1:0] REG_INT_ACK        = 12'h064;
   localparam logic [OFFSET_WIDTH-1:0] REG_STATUS         = 12'h070;
   localparam logic [OFFSET_WIDTH-1:0] REG_DESC_LOW       = 12'h080;
   localparam logic [OFFSET_WIDTH-1:0] REG_DESC_HIGH      = 12'h084;
   localparam logic [OFFSET_WIDTH-1:0] REG_DRIVER_LOW     = 12'h090;
   localparam logic [OFFSET_WIDTH-1:0] REG_DRIVER_HIGH    = 12'h094;
   localparam logic [OFFSET_WIDTH-1:0] REG_DEVICE_LOW     = 12'h0A0;
   localparam logic [OFFSET_WIDTH-1:0] REG_DEVICE_HIGH    = 12'h0A4;
   localparam logic [OFFSET_WIDTH-1:0] REG_CAPACITY_LOW   = 12'h100;
   localparam logic [OFFSET_WIDTH-1:0] REG_CAPACITY_HIGH  = 12'h104;

endpackage
`default_nettype wire

// File: rtl/vmblk_if.sv
// valid/ready channel interfaces of the virtio-mmio block register file
`default_nettype none
interface vmblk_req_if;
   logic                                  valid;
   logic                                  ready;
   vmblk_pkg::operation_type              operation;
   logic [vmblk_pkg::OFFSET_WIDTH-1:0]    offset;
   logic [vmblk_pkg::WORD_WIDTH-1:0]      write_data;

   modport source (output valid, output operation, output offset, output write_data,
                   input ready);
   modport sink   (input valid, input operation, input offset, input write_data,
                   output ready);
endinterface

interface vmblk_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [vmblk_pkg::WORD_WIDTH-1:0]      read_data;
   logic                                  start_queue;
   logic                                  irq;
   logic [vmblk_pkg::WORD_WIDTH-1:0]      queue_size;
   logic [vmblk_pkg::ADDRESS_WIDTH-1:0]   descriptor_area;
   logic [vmblk_pkg::ADDRESS_WIDTH-1:0]   driver_area;
   logic [vmblk_pkg::ADDRESS_WIDTH-1:0]   device_area;

   modport source (output valid, output read_data, output start_queue, output irq,
                   output queue_size, output descriptor_area, output driver_area,
                   output device_area, input ready);
   modport sink   (input valid, input read_data, input start_queue, input irq,
                   input queue_size, input descriptor_area, input driver_area,
                   input device_area, output ready);
endinterface

interface vmblk_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [vmblk_pkg::CAPACITY_WIDTH-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/virtio_mmio_block_register_file.sv
// virtio-mmio version 2 block device register file
// the result of an accepted word is registered and shown from the single result register
// throughput: one word per cycle; the single result register takes a new word whenever
// it is empty or being drained in the same cycle
// reset clears all device registers, the capacity and the result valid flag
`default_nettype none
module virtio_mmio_block_register_file #(
   parameter logic [vmblk_pkg::WORD_WIDTH-1:0] MAX_QUEUE_SIZE = vmblk_pkg::MAX_QUEUE_SIZE
) (
   input  wire               clock,
   input  wire               reset,
   vmblk_req_if.sink         req_if,
   vmblk_rsp_if.source       rsp_if,
   vmblk_csr_if.sink         csr_if
);

   logic [vmblk_pkg::CAPACITY_WIDTH-1:0] capacity_ff, capacity_in;
   logic [vmblk_pkg::WORD_WIDTH-1:0]     device_status_ff, device_status_in;
   logic [vmblk_pkg::WORD_WIDTH-1:0]     feature_select_ff, feature_select_in;
   logic [vmblk_pkg::WORD_WIDTH-1:0]     interrupt_status_ff, interrupt_status_in;
   logic [vmblk_pkg::WORD_WIDTH-1:0]     queue_select_ff, queue_select_in;
   logic [vmblk_pkg::WORD_WIDTH-1:0]     queue_length_ff, queue_length_in;
   logic                                 queue_is_ready_ff, queue_is_ready_in;
   logic [vmblk_pkg::ADDRESS_WIDTH-1:0]  desc_address_ff, desc_address_in;
   logic [vmblk_pkg::ADDRESS_WIDTH-1:0]  avail_address_ff, avail_address_in;
   logic [vmblk_pkg::ADDRESS_WIDTH-1:0]  used_address_ff, used_address_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [vmblk_pkg::WORD_WIDTH-1:0]     read_data_ff, read_data_in;
   logic                                 start_queue_ff, start_queue_in;
   logic                                 irq_ff, irq_in;

   logic                                 req_accept;
   logic                                 notify_ok;
   logic [vmblk_pkg::WORD_WIDTH-1:0]     read_value;
   logic [vmblk_pkg::WORD_WIDTH-1:0]     wdata;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign wdata        = req_if.write_data;

   // queue must be live and sized a nonzero power of two within the limit
   assign notify_ok = device_status_ff[vmblk_pkg::DRIVER_OK_BIT] && queue_is_ready_ff
                      && (queue_length_ff != '0)
                      && (queue_length_ff <= MAX_QUEUE_SIZE)
                      && ((queue_length_ff & (queue_length_ff - 32'd1)) == '0);

   always_comb begin
      case (req_if.offset)
         vmblk_pkg::REG_MAGIC:         read_value = vmblk_pkg::IDENTITY_MAGIC;
         vmblk_pkg::REG_VERSION:       read_value = vmblk_pkg::VERSION_VALUE;
         vmblk_pkg::REG_DEVICE_ID:     read_value = vmblk_pkg::DEVICE_ID_VALUE;
         vmblk_pkg::REG_VENDOR_ID:     read_value = vmblk_pkg::VENDOR_VALUE;
         vmblk_pkg::REG_DEV_FEATURES:  read_value = {31'd0, (feature_select_ff == 32'd1)};
         vmblk_pkg::REG_QUEUE_NUM_MAX: read_value = (queue_select_ff == '0)
                                                    ? MAX_QUEUE_SIZE : '0;
         vmblk_pkg::REG_QUEUE_READY:   read_value = {31'd0, queue_is_ready_ff};
         vmblk_pkg::REG_INT_STATUS:    read_value = interrupt_status_ff;
         vmblk_pkg::REG_STATUS:        read_value = device_status_ff;
         vmblk_pkg::REG_CAPACITY_LOW:  read_value = capacity_ff[31:0];
         vmblk_pkg::REG_CAPACITY_HIGH: read_value = {16'd0, capacity_ff[47:32]};
         default:                      read_value = '0;
      endcase
   end

   always_comb begin
      capacity_in         = capacity_ff;
      device_status_in    = device_status_ff;
      feature_select_in   = feature_select_ff;
      interrupt_status_in = interrupt_status_ff;
      queue_select_in     = queue_select_ff;
      queue_length_in     = queue_length_ff;
      queue_is_ready_in   = queue_is_ready_ff;
      desc_address_in     = desc_address_ff;
      avail_address_in    = avail_address_ff;
      used_address_in     = used_address_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_if.ready;
      read_data_in        = read_data_ff;
      start_queue_in      = start_queue_ff;
      irq_in              = irq_ff;

      if (csr_if.valid) begin
         capacity_in = csr_if.data;
      end

      if (req_accept) begin
         rsp_valid_in   = 1'b1;
         read_data_in   = '0;
         start_queue_in = 1'b0;
         irq_in         = 1'b0;
         case (req_if.operation)
            vmblk_pkg::OP_READ: begin
               read_data_in = read_value;
            end
            vmblk_pkg::OP_WRITE: begin
               case (req_if.offset)
                  vmblk_pkg::REG_DEV_FEAT_SEL: feature_select_in = wdata;
                  vmblk_pkg::REG_QUEUE_SEL:    queue_select_in   = wdata;
                  vmblk_pkg::REG_QUEUE_NUM:    queue_length_in   = wdata;
                  vmblk_pkg::REG_QUEUE_READY:  queue_is_ready_in = wdata[0];
                  vmblk_pkg::REG_QUEUE_NOTIFY: start_queue_in    = (wdata == '0) && notify_ok;
                  vmblk_pkg::REG_INT_ACK:      interrupt_status_in = interrupt_status_ff & ~wdata;
                  vmblk_pkg::REG_STATUS: begin
                     device_status_in = wdata;
                     // status write of zero resets the queue
                     if (wdata == '0) begin
                        queue_is_ready_in   = 1'b0;
                        queue_length_in     = '0;
                        interrupt_status_in = '0;
                        desc_address_in     = '0;
                        avail_address_in    = '0;
                        used_address_in     = '0;
                     end
                  end
                  vmblk_pkg::REG_DESC_LOW:    desc_address_in[31:0]   = wdata;
                  vmblk_pkg::REG_DESC_HIGH:   desc_address_in[63:32]  = wdata;
                  vmblk_pkg::REG_DRIVER_LOW:  avail_address_in[31:0]  = wdata;
                  vmblk_pkg::REG_DRIVER_HIGH: avail_address_in[63:32] = wdata;
                  vmblk_pkg::REG_DEVICE_LOW:  used_address_in[31:0]   = wdata;
                  vmblk_pkg::REG_DEVICE_HIGH: used_address_in[63:32]  = wdata;
                  default: begin
                  end
               endcase
            end
            vmblk_pkg::OP_COMPLETE: begin
               interrupt_status_in = interrupt_status_ff | 32'd1;
               irq_in              = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff         <= '0;
         device_status_ff    <= '0;
         feature_select_ff   <= '0;
         interrupt_status_ff <= '0;
         queue_select_ff     <= '0;
         queue_length_ff     <= '0;
         queue_is_ready_ff   <= 1'b0;
         desc_address_ff     <= '0;
         avail_address_ff    <= '0;
         used_address_ff     <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         capacity_ff         <= capacity_in;
         device_status_ff    <= device_status_in;
         feature_select_ff   <= feature_select_in;
         interrupt_status_ff <= interrupt_status_in;
         queue_select_ff     <= queue_select_in;
         queue_length_ff     <= queue_length_in;
         queue_is_ready_ff   <= queue_is_ready_in;
         desc_address_ff     <= desc_address_in;
         avail_address_ff    <= avail_address_in;
         used_address_ff     <= used_address_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
      read_data_ff   <= read_data_in;
      start_queue_ff <= start_queue_in;
      irq_ff         <= irq_in;
   end

   // queue state changes only together with a new result, so it is shown directly
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.read_data       = read_data_ff;
   assign rsp_if.start_queue     = start_queue_ff;
   assign rsp_if.irq             = irq_ff;
   assign rsp_if.queue_size      = queue_length_ff;
   assign rsp_if.descriptor_area = desc_address_ff;
   assign rsp_if.driver_area     = avail_address_ff;
   assign rsp_if.device_area     = used_address_ff;

`ifndef ASSERT_OFF
   a_irq_sets_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && irq_ff |-> interrupt_status_ff[0])
      else $error("irq result without interrupt status bit 0");

   a_start_needs_live_queue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && start_queue_ff |->
         queue_is_ready_ff && device_status_ff[vmblk_pkg::DRIVER_OK_BIT])
      else $error("start_queue while queue not live");

   a_start_no_read_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && start_queue_ff |-> (read_data_ff == '0) && !irq_ff)
      else $error("notify result carries read data or irq");

   a_reset_clears_valid: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
